[rtl/core/preprocessor_binary_alu_unit_defines.svh]
// assertion macros used by the binary alu top level
`ifndef PREPROCESSOR_BINARY_ALU_UNIT_DEFINES_SVH
`define PREPROCESSOR_BINARY_ALU_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define PBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba check failed");
// next-cycle implication, clocked on clk, off during reset
`define PBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba check failed");
`else
`define PBA_ASSERT_NOW(lbl, ante, cons)
`define PBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/pba_pkg.sv]
// types, constants and operator codes of the binary alu
`default_nettype none
package pba_pkg;
  localparam int ARITH_BITS = 64;
  localparam int DW = 64;
  localparam int AW = ARITH_BITS;
  localparam int SW = $clog2(AW);
  localparam int HW = AW / 2;
  localparam int LW = AW - HW;
  localparam logic [AW-1:0] AW_LIM = AW'(ARITH_BITS);

  typedef enum logic [4:0] {
    FN_DIV   = 5'd0,
    FN_MOD   = 5'd1,
    FN_MUL   = 5'd2,
    FN_ADD   = 5'd3,
    FN_SUB   = 5'd4,
    FN_SHL   = 5'd5,
    FN_SHR   = 5'd6,
    FN_LT    = 5'd7,
    FN_GT    = 5'd8,
    FN_LE    = 5'd9,
    FN_GE    = 5'd10,
    FN_EQ    = 5'd11,
    FN_NE    = 5'd12,
    FN_AND   = 5'd13,
    FN_XOR   = 5'd14,
    FN_OR    = 5'd15,
    FN_LAND  = 5'd16,
    FN_LOR   = 5'd17,
    FN_COMMA = 5'd18
  } func_t;

  // per-item control riding along the chain
  typedef struct packed {
    logic          is_div;
    logic          is_mod;
    logic          is_mul;
    logic          dz;
    logic          uns;
    logic          neg_q;
    logic          neg_r;
    logic [AW-1:0] a;
    logic [AW-1:0] res;
  } ctl_t;

  // divider working state
  typedef struct packed {
    logic [AW-1:0] rem;
    logic [AW-1:0] quo;
    logic [AW-1:0] dvs;
  } div_t;

  // multiplier partial products
  typedef struct packed {
    logic [AW-1:0] pll;
    logic [LW-1:0] pc1;
    logic [LW-1:0] pc2;
  } mul_t;
endpackage
`default_nettype wire

[rtl/core/pba_if.sv]
// valid/ready channel interfaces of the binary alu
`default_nettype none
interface pba_in_if;
  logic                     valid;
  logic                     ready;
  logic [4:0]               func;
  logic signed [pba_pkg::DW-1:0] left_value;
  logic                     left_unsigned;
  logic signed [pba_pkg::DW-1:0] right_value;
  logic                     right_unsigned;
  modport source(output valid, func, left_value, left_unsigned, right_value,
                 right_unsigned, input ready);
  modport sink(input valid, func, left_value, left_unsigned, right_value,
               right_unsigned, output ready);
endinterface

interface pba_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [pba_pkg::DW-1:0] result_value;
  logic                     result_unsigned;
  logic                     divide_by_zero;
  modport source(output valid, result_value, result_unsigned, divide_by_zero,
                 input ready);
  modport sink(input valid, result_value, result_unsigned, divide_by_zero,
               output ready);
endinterface
`default_nettype wire

[rtl/core/preprocessor_binary_alu_unit.sv]
// top level of the binary alu: prep stage, division cell chain, output register
//
// in_ch carries one operator evaluation per beat (func, both operands and
// their unsigned flags); out_ch returns exactly one result beat per input
// beat, in order. a beat moves when valid and ready are both high.
// a beat passes one decode stage, one cell per quotient bit of the restoring
// divider, and the output register.
// every operator goes through the same chain, so order is kept for free.
// throughput is one beat per cycle unless the receiver stalls; the whole chain advances together.
// a stalled receiver freezes the chain once the output register is full;
// in_ch.ready stays high while the output is empty or being taken, so a
// new beat enters in the same cycle a finished one leaves.
// reset (rst_n low, synchronous) clears all valid bits; payload registers
// are not reset.
// division or modulo by zero returns the left operand and raises
// divide_by_zero; signed min by -1 wraps.
`default_nettype none
`include "preprocessor_binary_alu_unit_defines.svh"
module preprocessor_binary_alu_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  pba_in_if.sink    in_ch,
  pba_out_if.source out_ch
);
  import pba_pkg::*;

  // chain advance: the output register is free or being drained
  logic          en;
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  logic          out_uns_r;
  logic          out_dz_r;

  logic          v0;
  ctl_t          c0;
  mul_t          m0;
  div_t          d0;
  ctl_t          c0_mix;

  logic          cv [0:AW];
  ctl_t          cc [0:AW];
  div_t          cd [0:AW];

  logic [AW-1:0] fin;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  pba_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_ch.valid),
    .in_func      (in_ch.func),
    .in_left      (in_ch.left_value),
    .in_left_uns  (in_ch.left_unsigned),
    .in_right     (in_ch.right_value),
    .in_right_uns (in_ch.right_unsigned),
    .valid_r      (v0),
    .ctl_r        (c0),
    .mul_r        (m0),
    .div_r        (d0)
  );

  // fold the multiply partial products into the result on the way in
  always_comb begin
    c0_mix = c0;
    if (c0.is_mul) begin
      c0_mix.res = m0.pll + {LW'(m0.pc1 + m0.pc2), {HW{1'b0}}};
    end
  end

  assign cv[0] = v0;
  assign cc[0] = c0_mix;
  assign cd[0] = d0;

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < AW; i++) begin : g_cell
    pba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (cv[i]),
      .in_ctl   (cc[i]),
      .in_div   (cd[i]),
      .valid_r  (cv[i+1]),
      .ctl_r    (cc[i+1]),
      .div_r    (cd[i+1])
    );
  end

  // sign fix of quotient and remainder, divide by zero passes the left value
  always_comb begin
    fin = cc[AW].res;
    if (cc[AW].dz) begin
      fin = cc[AW].a;
    end else if (cc[AW].is_div) begin
      fin = cc[AW].neg_q ? (AW'(0) - cd[AW].quo) : cd[AW].quo;
    end else if (cc[AW].is_mod) begin
      fin = cc[AW].neg_r ? (AW'(0) - cd[AW].rem) : cd[AW].rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[AW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= DW'($signed(fin));
      out_uns_r   <= cc[AW].uns;
      out_dz_r    <= cc[AW].dz;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_value    = out_value_r;
  assign out_ch.result_unsigned = out_uns_r;
  assign out_ch.divide_by_zero  = out_dz_r;

  // a taken beat shows up in the decode stage
  `PBA_ASSERT_NEXT(a_enter, in_ch.valid && in_ch.ready, v0)
  // the last cell hands its beat to the output register
  `PBA_ASSERT_NEXT(a_exit, cv[AW] && en, out_valid_r)
  // only div and mod can flag a zero divisor
  `PBA_ASSERT_NOW(a_dz_op, cv[AW] && cc[AW].dz, cc[AW].is_div || cc[AW].is_mod)
  // a full output register that is not taken holds the chain
  `PBA_ASSERT_NOW(a_hold, out_valid_r && !out_ch.ready, !in_ch.ready)
endmodule
`default_nettype wire

[rtl/core/pba_prep.sv]
// operand decode, simple operators and multiply partial products
`default_nettype none
module pba_prep (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [4:0]               in_func,
  input  wire logic [pba_pkg::DW-1:0]   in_left,
  input  wire logic                     in_left_uns,
  input  wire logic [pba_pkg::DW-1:0]   in_right,
  input  wire logic                     in_right_uns,
  output logic                          valid_r,
  output pba_pkg::ctl_t                 ctl_r,
  output pba_pkg::mul_t                 mul_r,
  output pba_pkg::div_t                 div_r
);
  import pba_pkg::*;

  logic [AW-1:0]   a, b, ma, mb, res;
  logic            uns, an, bn, big, bz;
  logic [SW-1:0]   sh;
  logic [2*HW-1:0] p0;
  logic [2*LW-1:0] p1, p2;
  ctl_t            ctl_nxt;
  mul_t            mul_nxt;
  div_t            div_nxt;

  always_comb begin
    a   = in_left[AW-1:0];
    b   = in_right[AW-1:0];
    uns = in_left_uns | in_right_uns;
    an  = a[AW-1];
    bn  = b[AW-1];
    bz  = (b == '0);
    big = (b >= AW_LIM);
    sh  = b[SW-1:0];
    ma  = an ? (AW'(0) - a) : a;
    mb  = bn ? (AW'(0) - b) : b;
    p0  = a[HW-1:0] * b[HW-1:0];
    p1  = LW'(a[HW-1:0]) * b[AW-1:HW];
    p2  = a[AW-1:HW] * LW'(b[HW-1:0]);
    res = a;
    unique case (in_func)
      FN_ADD:  res = a + b;
      FN_SUB:  res = a - b;
      FN_SHL:  res = big ? '0 : (a << sh);
      FN_SHR: begin
        if (bz)        res = a;
        else if (uns)  res = big ? '0 : (a >> sh);
        else if (big)  res = {AW{an}};
        else           res = AW'($signed(a) >>> sh);
      end
      FN_LT:   res = AW'(uns ? (a < b)  : ($signed(a) < $signed(b)));
      FN_GT:   res = AW'(uns ? (a > b)  : ($signed(a) > $signed(b)));
      FN_LE:   res = AW'(uns ? (a <= b) : ($signed(a) <= $signed(b)));
      FN_GE:   res = AW'(uns ? (a >= b) : ($signed(a) >= $signed(b)));
      FN_EQ:   res = AW'(a == b);
      FN_NE:   res = AW'(a != b);
      FN_AND:  res = a & b;
      FN_XOR:  res = a ^ b;
      FN_OR:   res = a | b;
      FN_LAND: res = AW'((a != '0) && !bz);
      FN_LOR:  res = AW'((a != '0) || !bz);
      FN_COMMA: res = b;
      default: res = a;
    endcase
    ctl_nxt.is_div = (in_func == FN_DIV);
    ctl_nxt.is_mod = (in_func == FN_MOD);
    ctl_nxt.is_mul = (in_func == FN_MUL);
    ctl_nxt.dz     = ((in_func == FN_DIV) || (in_func == FN_MOD)) && bz;
    ctl_nxt.uns    = (in_func == FN_COMMA) ? in_right_uns : uns;
    ctl_nxt.neg_q  = !uns && (an != bn);
    ctl_nxt.neg_r  = !uns && an;
    ctl_nxt.a      = a;
    ctl_nxt.res    = res;
    mul_nxt.pll    = AW'(p0);
    mul_nxt.pc1    = p1[LW-1:0];
    mul_nxt.pc2    = p2[LW-1:0];
    div_nxt.rem    = '0;
    div_nxt.quo    = uns ? a : ma;
    div_nxt.dvs    = uns ? b : mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      mul_r <= mul_nxt;
      div_r <= div_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/pba_cell.sv]
// one restoring division step, registered, with the item's control
`default_nettype none
module pba_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  pba_pkg::ctl_t       in_ctl,
  input  pba_pkg::div_t       in_div,
  output logic                valid_r,
  output pba_pkg::ctl_t       ctl_r,
  output pba_pkg::div_t       div_r
);
  import pba_pkg::*;

  logic [AW:0] trial;
  div_t        div_nxt;

  always_comb begin
    trial       = {in_div.rem, in_div.quo[AW-1]} - {1'b0, in_div.dvs};
    div_nxt.dvs = in_div.dvs;
    if (!trial[AW]) begin
      div_nxt.rem = trial[AW-1:0];
      div_nxt.quo = {in_div.quo[AW-2:0], 1'b1};
    end else begin
      div_nxt.rem = {in_div.rem[AW-2:0], in_div.quo[AW-1]};
      div_nxt.quo = {in_div.quo[AW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= in_ctl;
      div_r <= div_nxt;
    end
  end
endmodule
`default_nettype wire

[tb/preprocessor_binary_alu_unit_checker.sv]
// checker for the binary alu: watches both channels, predicts and compares results
`timescale 1ns / 1ps
module preprocessor_binary_alu_unit_checker (
  input  logic   clk,
  input  logic   rst_n,
  pba_in_if      in_ch,
  pba_out_if     out_ch,
  output int     fail_count,
  output int     pending
);
  import pba_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic        uns;
    logic        dz;
  } alu_result_t;

  alu_result_t result_queue[$];

  function automatic alu_result_t compute_alu(logic [4:0] fn, logic [63:0] a, logic la,
                                               logic [63:0] b, logic lb);
    alu_result_t r;
    logic uns;
    logic [63:0] ma, mb, q, m;
    logic an, bn;
    uns = la | lb;
    an = a[63];
    bn = b[63];
    r.value = a;
    r.dz = 1'b0;
    case (fn)
      FN_DIV, FN_MOD: begin
        if (b == 64'd0) begin
          r.dz = 1'b1;
        end else if (uns) begin
          r.value = (fn == FN_DIV) ? a / b : a % b;
        end else begin
          ma = an ? -a : a;
          mb = bn ? -b : b;
          q = ma / mb;
          m = ma % mb;
          if (fn == FN_DIV) r.value = (an != bn) ? -q : q;
          else r.value = an ? -m : m;
        end
      end
      FN_MUL: r.value = a * b;
      FN_ADD: r.value = a + b;
      FN_SUB: r.value = a - b;
      FN_SHL: r.value = (b >= 64) ? 64'd0 : a << b[5:0];
      FN_SHR: begin
        if (b != 0) begin
          if (uns) r.value = (b >= 64) ? 64'd0 : a >> b[5:0];
          else if (b >= 64) r.value = {64{an}};
          else r.value = $signed(a) >>> b[5:0];
        end
      end
      FN_LT: r.value = uns ? 64'(a < b) : 64'($signed(a) < $signed(b));
      FN_GT: r.value = uns ? 64'(a > b) : 64'($signed(a) > $signed(b));
      FN_LE: r.value = uns ? 64'(a <= b) : 64'($signed(a) <= $signed(b));
      FN_GE: r.value = uns ? 64'(a >= b) : 64'($signed(a) >= $signed(b));
      FN_EQ: r.value = 64'(a == b);
      FN_NE: r.value = 64'(a != b);
      FN_AND: r.value = a & b;
      FN_XOR: r.value = a ^ b;
      FN_OR: r.value = a | b;
      FN_LAND: r.value = 64'((a != 0) && (b != 0));
      FN_LOR: r.value = 64'((a != 0) || (b != 0));
      FN_COMMA: begin
        uns = lb;
        r.value = b;
      end
      default: ;
    endcase
    r.uns = uns;
    return r;
  endfunction

  assign pending = result_queue.size();

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) fail_count = 0;
    if (rst_n && in_ch.valid && in_ch.ready)
      result_queue.push_back(compute_alu(in_ch.func, in_ch.left_value, in_ch.left_unsigned,
                                         in_ch.right_value, in_ch.right_unsigned));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_queue.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = result_queue.pop_front();
        if (out_ch.result_value !== want.value) begin
          $error("result_value expected %h actual %h", want.value, out_ch.result_value);
          fail_count++;
        end
        if (out_ch.result_unsigned !== want.uns) begin
          $error("result_unsigned expected %b actual %b", want.uns, out_ch.result_unsigned);
          fail_count++;
        end
        if (out_ch.divide_by_zero !== want.dz) begin
          $error("divide_by_zero expected %b actual %b", want.dz, out_ch.divide_by_zero);
          fail_count++;
        end
      end
    end
  end
endmodule

[tb/preprocessor_binary_alu_unit_test.sv]
// testbench top for the binary alu: clock, reset, stimulus, sink stalls and verdict
`timescale 1ns / 1ps
module preprocessor_binary_alu_unit_test;
  import pba_pkg::*;

  localparam int LATENCY = ARITH_BITS + 2;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   hold_sink = 1'b0;   // long receiver hold-off request

  pba_in_if  in_ch();
  pba_out_if out_ch();

  preprocessor_binary_alu_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  preprocessor_binary_alu_unit_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("preprocessor_binary_alu_unit test failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // operand picker biased toward corners: zero, one, minus one, min, max, small counts
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7fff_ffff_ffff_ffff;
      5: return 64'($urandom_range(70));
      6: return -64'($urandom_range(5, 1));
      7: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // receiver: random ready, with a long hold when asked
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        out_ch.ready = 1'b0;
        @(negedge clk);
      end else begin
        stall = gap_length();
        out_ch.ready = (stall == 0);
        @(negedge clk);
        if (stall != 0) begin
          repeat (stall - 1) @(negedge clk);
          out_ch.ready = 1'b1;
          @(negedge clk);
        end
      end
    end
  end

  // one beat, held until taken
  task automatic send_beat(logic [4:0] fn, logic [63:0] a, logic la, logic [63:0] b,
                           logic lb);
    in_ch.valid = 1'b1;
    in_ch.func = fn;
    in_ch.left_value = a;
    in_ch.left_unsigned = la;
    in_ch.right_value = b;
    in_ch.right_unsigned = lb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    in_ch.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_random(bit no_gaps);
    int g;
    logic [4:0] fn;
    fn = ($urandom_range(49) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
    send_beat(fn, pick_operand(), 1'($urandom), pick_operand(), 1'($urandom));
    if (!no_gaps) begin
      g = gap_length();
      if (g != 0) idle_for(g);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_ADD;
    in_ch.left_value = '0;
    in_ch.left_unsigned = 1'b0;
    in_ch.right_value = '0;
    in_ch.right_unsigned = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed corners
    send_beat(FN_DIV, 64'h8000_0000_0000_0000, 1'b0, '1, 1'b0);      // min by -1 wraps
    send_beat(FN_MOD, 64'h8000_0000_0000_0000, 1'b0, '1, 1'b0);
    send_beat(FN_DIV, 64'd1234, 1'b0, 64'd0, 1'b0);                  // divide by zero
    send_beat(FN_MOD, '1, 1'b1, 64'd0, 1'b0);
    send_beat(FN_DIV, -64'd7, 1'b0, 64'd2, 1'b0);
    send_beat(FN_MOD, -64'd7, 1'b0, 64'd2, 1'b0);
    send_beat(FN_DIV, -64'd7, 1'b1, 64'd2, 1'b0);                    // unsigned divide
    send_beat(FN_MUL, 64'h7fff_ffff_ffff_ffff, 1'b0, 64'd2, 1'b0);
    send_beat(FN_ADD, 64'h7fff_ffff_ffff_ffff, 1'b0, 64'd1, 1'b0);
    send_beat(FN_SUB, 64'h8000_0000_0000_0000, 1'b0, 64'd1, 1'b1);
    send_beat(FN_SHL, 64'd1, 1'b0, 64'd64, 1'b0);                    // count too large
    send_beat(FN_SHL, 64'd1, 1'b0, 64'd63, 1'b0);
    send_beat(FN_SHR, '1, 1'b0, '1, 1'b0);                           // negative count, sign fill
    send_beat(FN_SHR, '1, 1'b1, 64'd4, 1'b0);                        // logical shift
    send_beat(FN_SHR, 64'h8000_0000_0000_0000, 1'b0, 64'd0, 1'b0);   // shift by zero
    send_beat(FN_LT, '1, 1'b0, 64'd0, 1'b0);
    send_beat(FN_GT, '1, 1'b0, 64'd0, 1'b1);
    send_beat(FN_LE, 64'd5, 1'b0, 64'd5, 1'b0);
    send_beat(FN_GE, 64'h8000_0000_0000_0000, 1'b1, 64'd1, 1'b0);
    send_beat(FN_EQ, '1, 1'b0, '1, 1'b0);
    send_beat(FN_NE, 64'd0, 1'b0, 64'd1, 1'b0);
    send_beat(FN_AND, '1, 1'b0, 64'h0f0f, 1'b0);
    send_beat(FN_XOR, '1, 1'b0, 64'h0f0f, 1'b0);
    send_beat(FN_OR, 64'd0, 1'b0, '1, 1'b0);
    send_beat(FN_LAND, 64'd3, 1'b0, 64'd0, 1'b0);
    send_beat(FN_LOR, 64'd0, 1'b1, 64'd0, 1'b0);
    send_beat(FN_COMMA, 64'd9, 1'b1, '1, 1'b0);                      // comma takes right flag
    send_beat(5'd25, 64'd42, 1'b0, 64'd1, 1'b1);                     // unknown operator

    // receiver holds off long while the sender keeps pushing, so the chain fills
    hold_sink = 1'b1;
    fork
      begin
        repeat (LATENCY * 3) @(negedge clk);
        hold_sink = 1'b0;
      end
      repeat (120) send_random(1'b1);
    join

    // sender pauses until everything drains
    idle_for(1);
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < 1650; i++) begin
      send_random(i % 300 < 60);   // some back-to-back stretches
    end
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("preprocessor_binary_alu_unit test passed");
    end else begin
      $display("preprocessor_binary_alu_unit test failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pba_pkg.sv
rtl/core/pba_if.sv
rtl/core/pba_prep.sv
rtl/core/pba_cell.sv
rtl/core/preprocessor_binary_alu_unit.sv
tb/preprocessor_binary_alu_unit_checker.sv
tb/preprocessor_binary_alu_unit_test.sv
